// ===== src/cts_pkg.sv =====
// Shared types, constants and character helpers for the token scanner.
`default_nettype none

package cts_pkg;

  localparam int POSITION_BITS = 32;
  localparam int KW_MAX_CHARS  = 6;
  localparam int KW_IDX_BITS   = (KW_MAX_CHARS > 1) ? $clog2(KW_MAX_CHARS) : 1;

  localparam int KIND_BITS  = 5;
  localparam int START_BITS = 32;
  localparam int LEN_BITS   = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_BITS-1:0] K_ID      = 5'd0;
  localparam logic [KIND_BITS-1:0] K_INTEGER = 5'd10;
  localparam logic [KIND_BITS-1:0] K_DECIMAL = 5'd11;
  localparam logic [KIND_BITS-1:0] K_GT      = 5'd12;
  localparam logic [KIND_BITS-1:0] K_GE      = 5'd13;
  localparam logic [KIND_BITS-1:0] K_SHR     = 5'd14;
  localparam logic [KIND_BITS-1:0] K_LT      = 5'd15;
  localparam logic [KIND_BITS-1:0] K_SHL     = 5'd16;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd17;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd18;
  localparam logic [KIND_BITS-1:0] K_INC     = 5'd19;
  localparam logic [KIND_BITS-1:0] K_PLUSEQ  = 5'd20;
  localparam logic [KIND_BITS-1:0] K_DIV     = 5'd21;
  localparam logic [KIND_BITS-1:0] K_SEP     = 5'd22;
  localparam logic [KIND_BITS-1:0] K_ERROR   = 5'd23;

  localparam logic [7:0] CH_END = 8'h00;

  // Keywords in kind order, left-justified and padded with zero bytes.
  localparam int KW_COUNT    = 9;
  localparam int KW_TEXT_LEN = 6;
  localparam logic [KW_TEXT_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    {"if", 32'h0}, {"int", 24'h0}, {"float", 8'h0}, "return", {"main", 16'h0},
    {"while", 8'h0}, {"cin", 24'h0}, {"cout", 16'h0}, {"end", 24'h0}
  };
  localparam int KW_LEN [KW_COUNT] = '{2, 3, 5, 6, 4, 5, 3, 4, 3};

  typedef logic [KW_MAX_CHARS-1:0][7:0] kw_chars_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   len;
    logic                  last;
  } cts_result_t;

  typedef struct packed {
    logic [1:0]  count;
    cts_result_t res0;
    cts_result_t res1;
  } cts_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]}) || (c == 8'h5f);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0a};
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2c, 8'h3b};
  endfunction

  // Parallel compare of the buffered identifier against every keyword.
  function automatic logic [KIND_BITS-1:0] ident_kind(input kw_chars_t chars,
                                                     input logic [LEN_BITS-1:0] len,
                                                     input logic too_long);
    logic [KIND_BITS-1:0] kind;
    logic                 hit;
    kind = K_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == LEN_BITS'(KW_LEN[i])) && !too_long;
      for (int j = 0; j < KW_TEXT_LEN; j++) begin
        if (j < KW_LEN[i] &&
            chars[j] != KW_TEXT[i][(KW_TEXT_LEN-1-j)*8 +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_BITS'(i + 1);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== src/c_subset_token_scanner_core.sv =====
// Top level of the token scanner: input register, scanner step and result queue.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_ch
//   out_     output     out_valid / out_ready  out_token_kind, out_lexeme_start,
//                                               out_lexeme_length, out_run_end
//
// One character is accepted per cycle while the scan step is not waiting; it is held in
// the input register until its scan step, which writes its results into the result queue.
// A character gives zero, one or two results; the output side delivers one beat
// per cycle while out_ready is high, so the rate is one character per cycle while results keep up.
// The scan step waits whenever the result queue lacks room for two results.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module c_subset_token_scanner_core
  import cts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_ch,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [KIND_BITS-1:0]       out_token_kind,
  output logic [START_BITS-1:0]      out_lexeme_start,
  output logic [LEN_BITS-1:0]        out_lexeme_length,
  output logic                       out_run_end
);

  logic        in_v_r;
  logic [7:0]  in_ch_r;
  logic        room, step;
  cts_push_t   push;
  cts_result_t head;

  assign step     = in_v_r && room;
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r <= in_ch;
    end
  end

  cts_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (in_ch_r),
    .push  (push)
  );

  cts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (step),
    .push      (push),
    .room      (room),
    .pop       (out_valid && out_ready),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_token_kind    = head.kind;
  assign out_lexeme_start  = head.start;
  assign out_lexeme_length = head.len;
  assign out_run_end       = head.last;

`ifndef NO_ASSERTIONS
  a_result_shows : assert property (@(posedge clk) disable iff (!rst_n)
    step && push.count != 2'd0 |=> out_valid)
    else $error("scanned results did not reach the output");

  a_char_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r)
    else $error("waiting character dropped before its scan step");

  a_out_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_lexeme_start) && $stable(out_lexeme_length) && $stable(out_run_end))
    else $error("waiting result beat changed before it was taken");
`endif

endmodule

`default_nettype wire

// ===== src/cts_scan.sv =====
// Scanner automaton: one character step, token state and up to two results.
`default_nettype none

module cts_scan
  import cts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  output cts_push_t       push
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_INT   = 4'd1,
    S_DOT   = 4'd2,
    S_DEC   = 4'd3,
    S_IDENT = 4'd4,
    S_GT    = 4'd5,
    S_LT    = 4'd8,
    S_PLUS  = 4'd11
  } scan_state_t;

  scan_state_t              state_r, state_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt, len_inc;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     too_long_r, too_long_nxt;
  kw_chars_t                kw_chars_r;
  logic                     kw_wr;
  logic [KW_IDX_BITS-1:0]   kw_idx;

  logic                     close_first, do_idle, idle_emit;
  logic [KIND_BITS-1:0]     first_kind, idle_kind;
  logic [POSITION_BITS-1:0] first_start;
  logic [LEN_BITS-1:0]      first_len;
  cts_result_t              first_res, idle_res;

  always_comb begin
    len_inc      = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
    state_nxt    = state_r;
    len_nxt      = len_r;
    start_nxt    = start_r;
    too_long_nxt = too_long_r;
    kw_wr        = 1'b0;
    kw_idx       = len_r[KW_IDX_BITS-1:0];
    close_first  = 1'b0;
    first_kind   = K_ID;
    first_start  = start_r;
    first_len    = len_r;
    do_idle      = 1'b0;
    idle_emit    = 1'b0;
    idle_kind    = K_ERROR;

    case (state_r)
      S_INT: begin
        if (is_digit(ch)) begin
          len_nxt = len_inc;
        end else if (ch == 8'h2e) begin
          len_nxt   = len_inc;
          state_nxt = S_DOT;
        end else begin
          close_first = 1'b1;
          first_kind  = K_INTEGER;
          do_idle     = 1'b1;
        end
      end
      S_DOT: begin
        if (is_digit(ch)) begin
          len_nxt   = len_inc;
          state_nxt = S_DEC;
        end else begin
          // A dot with no digit after it: drop the number, report at this character.
          close_first = 1'b1;
          first_kind  = K_ERROR;
          first_start = pos_r;
          first_len   = '0;
          do_idle     = 1'b1;
        end
      end
      S_DEC: begin
        if (is_digit(ch)) begin
          len_nxt = len_inc;
        end else begin
          close_first = 1'b1;
          first_kind  = K_DECIMAL;
          do_idle     = 1'b1;
        end
      end
      S_IDENT: begin
        if (is_alpha(ch) || is_digit(ch)) begin
          if (!too_long_r && len_r < LEN_BITS'(KW_MAX_CHARS)) begin
            kw_wr = 1'b1;
          end else begin
            too_long_nxt = 1'b1;
          end
          len_nxt = len_inc;
        end else begin
          close_first = 1'b1;
          first_kind  = ident_kind(kw_chars_r, len_r, too_long_r);
          do_idle     = 1'b1;
        end
      end
      S_GT: begin
        close_first = 1'b1;
        if (ch == 8'h3d || ch == 8'h3e) begin
          first_kind = (ch == 8'h3d) ? K_GE : K_SHR;
          first_len  = len_inc;
          state_nxt  = S_IDLE;
        end else begin
          first_kind = K_GT;
          do_idle    = 1'b1;
        end
      end
      S_LT: begin
        close_first = 1'b1;
        if (ch == 8'h3c) begin
          first_kind = K_SHL;
          first_len  = len_inc;
          state_nxt  = S_IDLE;
        end else begin
          first_kind = K_LT;
          do_idle    = 1'b1;
        end
      end
      S_PLUS: begin
        close_first = 1'b1;
        if (ch == 8'h2b || ch == 8'h3d) begin
          first_kind = (ch == 8'h2b) ? K_INC : K_PLUSEQ;
          first_len  = len_inc;
          state_nxt  = S_IDLE;
        end else begin
          first_kind = K_PLUS;
          do_idle    = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // The character that ended a token, or any character in idle, starts over here.
    if (do_idle) begin
      state_nxt = S_IDLE;
      if (ch == CH_END || is_space(ch)) begin
        idle_emit = 1'b0;
      end else if (is_digit(ch) || is_alpha(ch) ||
                   ch == 8'h3e || ch == 8'h3c || ch == 8'h2b) begin
        start_nxt    = pos_r;
        len_nxt      = LEN_BITS'(1);
        too_long_nxt = 1'b0;
        if (is_digit(ch)) begin
          state_nxt = S_INT;
        end else if (is_alpha(ch)) begin
          state_nxt = S_IDENT;
          kw_wr     = 1'b1;
          kw_idx    = '0;
        end else if (ch == 8'h3e) begin
          state_nxt = S_GT;
        end else if (ch == 8'h3c) begin
          state_nxt = S_LT;
        end else begin
          state_nxt = S_PLUS;
        end
      end else begin
        idle_emit = 1'b1;
        if (ch == 8'h3d) begin
          idle_kind = K_ASSIGN;
        end else if (ch == 8'h2f) begin
          idle_kind = K_DIV;
        end else if (is_sep(ch)) begin
          idle_kind = K_SEP;
        end else begin
          idle_kind = K_ERROR;
        end
      end
    end

    pos_nxt = (ch == CH_END) ? '0 : pos_r + 1'b1;

    first_res = '{kind: first_kind, start: START_BITS'(first_start), len: first_len,
                  last: !idle_emit};
    idle_res  = '{kind: idle_kind, start: START_BITS'(pos_r), len: LEN_BITS'(1),
                  last: 1'b1};

    push = '0;
    if (close_first) begin
      push.res0  = first_res;
      push.res1  = idle_res;
      push.count = idle_emit ? 2'd2 : 2'd1;
    end else if (idle_emit) begin
      push.res0  = idle_res;
      push.res1  = idle_res;
      push.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      start_r    <= '0;
      pos_r      <= '0;
      too_long_r <= 1'b0;
    end else if (step) begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      start_r    <= start_nxt;
      pos_r      <= pos_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && kw_wr) begin
      kw_chars_r[kw_idx] <= ch;
    end
  end

`ifndef NO_ASSERTIONS
  a_pending_len : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> len_r != '0)
    else $error("pending token with zero length");

  a_dot_len : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DOT |-> len_r >= LEN_BITS'(2))
    else $error("number-then-dot state without a digit before it");

  a_kw_fits : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDENT && !too_long_r |-> len_r <= LEN_BITS'(KW_MAX_CHARS))
    else $error("keyword buffer overrun while the identifier still fits");
`endif

endmodule

`default_nettype wire

// ===== src/cts_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one beat per cycle while popped.
`default_nettype none

module cts_fifo
  import cts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_en,
  input  wire cts_push_t push,
  output logic       room,
  input  wire logic  pop,
  output logic       out_valid,
  output cts_result_t head
);

  cts_result_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_CW-1:0]   n_push;

  always_comb begin
    n_push     = push_en ? FIFO_CW'(push.count) : '0;
    count_nxt  = count_r + n_push - FIFO_CW'(pop);
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    room       = count_r <= FIFO_CW'(FIFO_DEPTH - 2);
    out_valid  = count_r != '0;
    head       = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (n_push == FIFO_CW'(2)) begin
      mem_r[FIFO_AW'(wr_ptr_r + 1'b1)] <= push.res1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count past its depth");

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    n_push != '0 |-> room)
    else $error("results pushed without room for two");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("beat taken from an empty result queue");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the token scanner: directed tests and random source text with a scoreboard.
module testbench;
  import cts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_INT   = 4'd1,
    ST_DOT   = 4'd2,
    ST_DEC   = 4'd3,
    ST_IDENT = 4'd4,
    ST_GT    = 4'd5,
    ST_LT    = 4'd8,
    ST_PLUS  = 4'd11
  } scan_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_ch = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_BITS-1:0]  out_token_kind;
  logic [START_BITS-1:0] out_lexeme_start;
  logic [LEN_BITS-1:0]   out_lexeme_length;
  logic                  out_run_end;

  c_subset_token_scanner_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ch             (in_ch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_lexeme_start  (out_lexeme_start),
    .out_lexeme_length (out_lexeme_length),
    .out_run_end       (out_run_end)
  );

  always #2 clk = ~clk;

  string kw_words [9] = '{"if", "int", "float", "return", "main", "while", "cin", "cout",
                          "end"};
  string op_words [10] = '{">", ">=", ">>", "<", "<<", "=", "+", "++", "+=", "/"};
  string sep_chars = "(){},;";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // Scanner state mirrored from the character stream.
  scan_phase_t           scan_st = ST_IDLE;
  logic [7:0]            kw_buf [KW_MAX_CHARS];
  logic [LEN_BITS-1:0]   tok_len = '0;
  logic [START_BITS-1:0] tok_start = '0;
  logic [31:0]           char_pos = '0;
  logic                  too_long = 1'b0;

  cts_result_t step_res [2];
  int          step_n;
  cts_result_t expected_tokens [$];

  int fail_count = 0;
  int items_sent = 0;
  bit valid_idle_on = 1'b0;
  bit ready_idle_on = 1'b0;
  int ready_hold = 0;

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit space_ch(input logic [7:0] c);
    return c == " " || c == "\t" || c == "\n";
  endfunction

  function automatic void emit(input logic [KIND_BITS-1:0] kind,
                               input logic [START_BITS-1:0] start,
                               input logic [LEN_BITS-1:0] len);
    step_res[step_n].kind  = kind;
    step_res[step_n].start = start;
    step_res[step_n].len   = len;
    step_res[step_n].last  = 1'b0;
    step_n++;
  endfunction

  function automatic void lengthen();
    if (tok_len != LEN_MAX) tok_len++;
  endfunction

  function automatic void open_token(input scan_phase_t st, input logic [31:0] pos);
    scan_st   = st;
    tok_start = pos;
    tok_len   = 1;
    too_long  = 1'b0;
  endfunction

  function automatic logic [KIND_BITS-1:0] keyword_kind();
    bit hit;
    if (too_long || tok_len > KW_MAX_CHARS) return K_ID;
    for (int i = 0; i < 9; i++) begin
      if (kw_words[i].len() == tok_len) begin
        hit = 1'b1;
        for (int j = 0; j < kw_words[i].len(); j++)
          if (kw_words[i][j] != kw_buf[j]) hit = 1'b0;
        if (hit) return KIND_BITS'(i + 1);
      end
    end
    return K_ID;
  endfunction

  function automatic void restart_from_idle(input logic [7:0] c, input logic [31:0] pos);
    scan_st = ST_IDLE;
    if (c != CH_END && !space_ch(c)) begin
      if (digit_ch(c)) begin
        open_token(ST_INT, pos);
      end else if (letter_ch(c)) begin
        open_token(ST_IDENT, pos);
        kw_buf[0] = c;
      end else if (c == ">") begin
        open_token(ST_GT, pos);
      end else if (c == "<") begin
        open_token(ST_LT, pos);
      end else if (c == "+") begin
        open_token(ST_PLUS, pos);
      end else if (c == "=") begin
        emit(K_ASSIGN, pos, 1);
      end else if (c == "/") begin
        emit(K_DIV, pos, 1);
      end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "," || c == ";") begin
        emit(K_SEP, pos, 1);
      end else begin
        emit(K_ERROR, pos, 1);
      end
    end
  endfunction

  function automatic void close_then_restart(input logic [KIND_BITS-1:0] kind,
                                             input logic [7:0] c, input logic [31:0] pos);
    emit(kind, tok_start, tok_len);
    restart_from_idle(c, pos);
  endfunction

  function automatic void close_pair(input logic [KIND_BITS-1:0] kind);
    lengthen();
    emit(kind, tok_start, tok_len);
    scan_st = ST_IDLE;
  endfunction

  // Advances the mirrored scanner by one character and queues the tokens it yields.
  function automatic void predict_char(input logic [7:0] c);
    logic [31:0] pos;
    pos = char_pos;
    step_n = 0;
    case (scan_st)
      ST_INT: begin
        if (digit_ch(c)) lengthen();
        else if (c == ".") begin
          lengthen();
          scan_st = ST_DOT;
        end else close_then_restart(K_INTEGER, c, pos);
      end
      ST_DOT: begin
        if (digit_ch(c)) begin
          lengthen();
          scan_st = ST_DEC;
        end else begin
          // The integer and its dot are dropped; only a zero-length error remains.
          emit(K_ERROR, pos, 0);
          restart_from_idle(c, pos);
        end
      end
      ST_DEC: begin
        if (digit_ch(c)) lengthen();
        else close_then_restart(K_DECIMAL, c, pos);
      end
      ST_IDENT: begin
        if (letter_ch(c) || digit_ch(c)) begin
          if (!too_long && tok_len < KW_MAX_CHARS) kw_buf[tok_len] = c;
          else too_long = 1'b1;
          lengthen();
        end else close_then_restart(keyword_kind(), c, pos);
      end
      ST_GT: begin
        if (c == "=") close_pair(K_GE);
        else if (c == ">") close_pair(K_SHR);
        else close_then_restart(K_GT, c, pos);
      end
      ST_LT: begin
        if (c == "<") close_pair(K_SHL);
        else close_then_restart(K_LT, c, pos);
      end
      ST_PLUS: begin
        if (c == "+") close_pair(K_INC);
        else if (c == "=") close_pair(K_PLUSEQ);
        else close_then_restart(K_PLUS, c, pos);
      end
      default: restart_from_idle(c, pos);
    endcase
    for (int i = 0; i < step_n; i++) begin
      step_res[i].last = (i == step_n - 1);
      expected_tokens.push_back(step_res[i]);
    end
    char_pos = (c == CH_END) ? '0 : pos + 1;
  endfunction

  task automatic send_char(input logic [7:0] c);
    if (valid_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    predict_char(c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_char(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic send_word_tail(input int n);
    for (int i = 0; i < n; i++) send_char(word_chars[$urandom_range(0, word_chars.len() - 1)]);
  endtask

  // Holds the input idle until every queued token has been delivered.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Result side: every beat is checked against the oldest queued token.
  always @(posedge clk) begin : check_results
    cts_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected beat: kind %0d start %0d len %0d end %0b",
                   out_token_kind, out_lexeme_start, out_lexeme_length, out_run_end);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_kind !== want.kind || out_lexeme_start !== want.start ||
            out_lexeme_length !== want.len || out_run_end !== want.last) begin
          if (fail_count < 10)
            $display("token mismatch: want kind %0d start %0d len %0d end %0b, got %0d %0d %0d %0b",
                     want.kind, want.start, want.len, want.last,
                     out_token_kind, out_lexeme_start, out_lexeme_length, out_run_end);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (ready_idle_on && $urandom_range(0, 6) == 0) begin
      ready_hold <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_odd_bytes();
    send_char(CH_END);
    send_char(8'hff);
    send_char(8'h7f);
    send_char(8'h0d);
    send_char(8'h80);
    wait_drained();
  endtask

  task automatic test_operator_pairs();
    send_text(">=>>><<<++=+=/");
    wait_drained();
  endtask

  task automatic test_number_forms();
    // A decimal flushed by end of text, then a dot left dangling before a separator.
    send_text("7.5");
    send_char(CH_END);
    send_text("9.;");
    send_char(CH_END);
    wait_drained();
  endtask

  task automatic test_long_identifier();
    valid_idle_on = 1'b0;
    ready_idle_on = 1'b0;
    send_char("L");
    send_word_tail(40);
    send_char(" ");
    wait_drained();
  endtask

  task automatic send_random_token();
    int    pick;
    string kw;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_text(kw_words[$urandom_range(0, 8)]);
    end else if (pick < 23) begin
      // Near misses: a keyword cut short or grown by one character.
      kw = kw_words[$urandom_range(0, 8)];
      if ($urandom_range(0, 1)) send_text(kw.substr(0, kw.len() - 2));
      else begin
        send_text(kw);
        send_word_tail(1);
      end
    end else if (pick < 38) begin
      send_char(word_chars[$urandom_range(0, 52)]);
      send_word_tail($urandom_range(0, ($urandom_range(0, 3) == 0) ? 12 : 7));
    end else if (pick < 50) begin
      send_digits($urandom_range(1, 6));
    end else if (pick < 58) begin
      send_digits($urandom_range(1, 4));
      send_char(".");
      send_digits($urandom_range(1, 4));
    end else if (pick < 63) begin
      send_digits($urandom_range(1, 3));
      send_char(".");
    end else if (pick < 80) begin
      send_text(op_words[$urandom_range(0, 9)]);
    end else if (pick < 90) begin
      send_char(sep_chars[$urandom_range(0, 5)]);
    end else if (pick < 95) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_char(CH_END);
    end else begin
      case ($urandom_range(0, 2))
        0: send_char(".");
        1: send_char(8'h0d);
        default: send_char(8'($urandom_range(128, 255)));
      endcase
    end
    if ($urandom_range(0, 9) < 6) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 2))
          0: send_char(" ");
          1: send_char("\t");
          default: send_char("\n");
        endcase
      end
    end
  endtask

  task automatic test_random_source(input int count, input bit allow_idle);
    int first;
    first = items_sent;
    valid_idle_on = allow_idle;
    ready_idle_on = allow_idle;
    while (items_sent - first < count) begin
      send_random_token();
      if (allow_idle && $urandom_range(0, 39) == 0) begin
        valid_idle_on = $urandom_range(0, 1);
        ready_idle_on = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_odd_bytes();
    test_operator_pairs();
    test_number_forms();
    test_long_identifier();
    test_random_source(1450, 1'b1);
    test_random_source(430, 1'b0);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
